>>> rtl/fan_speed_policy_hysteresis_defines.svh
// Assertion macros for the fan speed policy block.
`ifndef FAN_SPEED_POLICY_HYSTERESIS_DEFINES_SVH
`define FAN_SPEED_POLICY_HYSTERESIS_DEFINES_SVH

// Checked only outside reset.
`define FSPH_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSPH_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fsph_pkg.sv
// Shared types, constants and helpers of the fan speed policy block.
`default_nettype none

package fsph_pkg;

  typedef enum logic [1:0] {
    REG_BASE_SPEED = 2'd0,
    REG_CPU_THRESH = 2'd1,
    REG_GPU_THRESH = 2'd2,
    REG_TWO_FANS   = 2'd3
  } reg_index_t;

  localparam logic [7:0] BASE_SPEED_RESET = 8'd64;
  localparam logic [7:0] CPU_THRESH_RESET = 8'd50;
  localparam logic [7:0] GPU_THRESH_RESET = 8'd70;
  localparam logic       TWO_FANS_RESET   = 1'b1;
  localparam logic signed [9:0] REM_RESET = -10'sd80;
  localparam logic [7:0] DUTY_RESET       = 8'd0;
  localparam logic [7:0] DUTY_MAX         = 8'd255;
  localparam logic [7:0] DUTY_STOP        = 8'd0;

  typedef struct packed {
    logic [7:0] base_speed;
    logic [7:0] cpu_thresh;
    logic [7:0] gpu_thresh;
    logic       two_fans;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] cpu_excess;
    logic signed [8:0] gpu_excess;
    logic              gpu_slot;
  } tick_t;

  typedef struct packed {
    logic       fan_index;
    logic [7:0] duty;
    logic       last_of_tick;
  } res_t;

  // (255 - base) / 7 as a multiply by 293/2048, exact for 8-bit spans
  function automatic logic [5:0] step_of(input logic [7:0] base);
    logic [7:0]  span;
    logic [16:0] prod;
    span = DUTY_MAX - base;
    prod = 17'(span) * 17'd293;
    return prod[16:11];
  endfunction

endpackage

`default_nettype wire

>>> rtl/fan_speed_policy_hysteresis.sv
// Top level of the fan speed policy block: registers, front, back, result queue.
`default_nettype none

// One tick (a CPU and a GPU temperature) is taken per push and yields zero, one
// or two fan commands (fan, duty, last_of_tick) on the result queue. The front
// forms both excesses and queues up to two ticks; the back takes one tick per
// cycle when it has nothing left to send or is sending its last command, and
// sends one command per cycle while the result queue is not full. Registers are
// written through cfg_we, cfg_addr and cfg_data; the user must write them only
// while no tick is in flight, as the block does not enforce this.
module fan_speed_policy_hysteresis import fsph_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] cpu_temp,
  input  wire logic [7:0] gpu_temp,
  output logic            empty,
  input  wire logic       pop,
  output logic            fan_index,
  output logic [7:0]      duty,
  output logic            last_of_tick
);

  cfg_t  cfg;
  logic  tick_valid;
  tick_t tick;
  logic  tick_pop;
  logic  res_push;
  res_t  res;
  logic  res_full;
  res_t  head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_speed <= BASE_SPEED_RESET;
      cfg.cpu_thresh <= CPU_THRESH_RESET;
      cfg.gpu_thresh <= GPU_THRESH_RESET;
      cfg.two_fans   <= TWO_FANS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_BASE_SPEED: cfg.base_speed <= cfg_data;
        REG_CPU_THRESH: cfg.cpu_thresh <= cfg_data;
        REG_GPU_THRESH: cfg.gpu_thresh <= cfg_data;
        REG_TWO_FANS:   cfg.two_fans   <= cfg_data[0];
        default:        cfg            <= cfg;
      endcase
    end
  end

  fsph_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .cpu_temp   (cpu_temp),
    .gpu_temp   (gpu_temp),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_pop   (tick_pop)
  );

  fsph_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_pop   (tick_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  fsph_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign fan_index    = head.fan_index;
  assign duty         = head.duty;
  assign last_of_tick = head.last_of_tick;

endmodule

`default_nettype wire

>>> rtl/fsph_front.sv
// Front part: forms the channel excesses of a tick and queues them.
`default_nettype none

module fsph_front import fsph_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] cpu_temp,
  input  wire logic [7:0] gpu_temp,
  output logic            tick_valid,
  output tick_t           tick,
  input  wire logic       tick_pop
);

  tick_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  tick_t      incoming;

  always_comb begin
    incoming.cpu_excess = $signed({1'b0, cpu_temp}) - $signed({1'b0, cfg.cpu_thresh});
    incoming.gpu_excess = $signed({1'b0, gpu_temp}) - $signed({1'b0, cfg.gpu_thresh});
    incoming.gpu_slot   = cfg.two_fans;
  end

  assign full       = (count == 2'd2);
  assign tick_valid = (count != 2'd0);
  assign tick       = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = tick_pop && tick_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fsph_back.sv
// Back part: hysteresis decision, fan state and command emission.
`default_nettype none

module fsph_back import fsph_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  tick_valid,
  input  wire tick_t tick,
  output logic       tick_pop,
  output logic       res_push,
  output res_t       res,
  input  wire logic  res_full
);

  logic signed [9:0]  rem [2];
  logic [7:0]         cur [2];
  logic [5:0]         step;
  logic               pend0;
  logic               pend1;
  logic [7:0]         pend_duty;

  logic signed [9:0]  rem_gpu;
  logic signed [10:0] diff0;
  logic signed [10:0] diff1;
  logic               hit0;
  logic               hit1;
  logic               cold;
  logic               act;
  logic signed [8:0]  sel_excess;
  logic [7:0]         sel_m1;
  logic [13:0]        prod;
  logic [14:0]        sum;
  logic [7:0]         speed;
  logic [7:0]         target;
  logic               emit0;
  logic               emit1;
  logic               load_ok;
  logic               load;
  logic               rem_idx;

  always_comb begin
    rem_gpu = rem[tick.gpu_slot];
    diff0   = 11'(tick.cpu_excess) - 11'(rem[0]);
    diff1   = 11'(tick.gpu_excess) - 11'(rem_gpu);
    hit0    = !tick.cpu_excess[8] && (diff0 > 11'sd1 || diff0 < -11'sd1);
    hit1    = !hit0 && !tick.gpu_excess[8] && (diff1 > 11'sd1 || diff1 < -11'sd1);
    cold    = !hit0 && (tick.gpu_excess < -9'sd2) && (tick.cpu_excess < -9'sd1);
    act     = hit0 || hit1 || cold;
    rem_idx = hit0 ? 1'b0 : tick.gpu_slot;

    sel_excess = hit0 ? tick.cpu_excess : tick.gpu_excess;
    sel_m1     = sel_excess[7:0] - 8'd1;
    prod       = 14'(sel_m1) * 14'(step);
    sum        = 15'(cfg.base_speed) + 15'(prod);
    if (sel_excess[7:0] == 8'd0) begin
      speed = cfg.base_speed;
    end else if (sum > 15'(DUTY_MAX)) begin
      speed = DUTY_MAX;
    end else begin
      speed = sum[7:0];
    end
    target = (hit0 || hit1) ? speed : DUTY_STOP;
    emit0  = (target != cur[0]);
    emit1  = cfg.two_fans && (target != cur[1]);
  end

  always_comb begin
    res_push         = (pend0 || pend1) && !res_full;
    res.fan_index    = !pend0;
    res.duty         = pend_duty;
    res.last_of_tick = !(pend0 && pend1);
    load_ok          = !(pend0 || pend1) || ((pend0 ^ pend1) && res_push);
    load             = tick_valid && load_ok;
    tick_pop         = load;
  end

  always_ff @(posedge clk) begin
    step <= step_of(cfg.base_speed);
    if (load && act) begin
      pend_duty <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem[0] <= REM_RESET;
      rem[1] <= REM_RESET;
      cur[0] <= DUTY_RESET;
      cur[1] <= DUTY_RESET;
      pend0  <= 1'b0;
      pend1  <= 1'b0;
    end else begin
      if (load && act) begin
        if (hit0 || hit1) begin
          rem[rem_idx] <= 10'(sel_excess);
        end
        cur[0] <= target;
        if (cfg.two_fans) begin
          cur[1] <= target;
        end
        pend0 <= emit0;
        pend1 <= emit1;
      end else if (res_push) begin
        if (pend0) begin
          pend0 <= 1'b0;
        end else begin
          pend1 <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fsph_outq.sv
// Result queue: holds fan commands until they are taken.
`default_nettype none

module fsph_outq import fsph_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_push,
  input  wire res_t res,
  output logic      res_full,
  output logic      empty,
  input  wire logic pop,
  output res_t      head
);

  res_t       entry [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign head     = entry[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fsph_checker.sv
// Port-level checks of the fan speed policy block and their binding.
`default_nettype none

`include "fan_speed_policy_hysteresis_defines.svh"

module fsph_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       fan_index,
  input wire logic [7:0] duty,
  input wire logic       last_of_tick
);

  `FSPH_ASSERT_ALL(a_reset_clears, rst |=> (empty && !full), "queues not cleared by reset")
  `FSPH_ASSERT_RUN(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(duty) && $stable(fan_index) && $stable(last_of_tick)), "stalled result changed")
  `FSPH_ASSERT_RUN(a_first_is_fan0, (!empty && !last_of_tick) |-> (fan_index == 1'b0), "non-final command not for first fan")
  `FSPH_ASSERT_RUN(a_pair_follows, (!empty && pop && !last_of_tick) |=> (!empty && fan_index && last_of_tick), "second fan command missing after first")

endmodule

bind fan_speed_policy_hysteresis fsph_checker u_fsph_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .fan_index    (fan_index),
  .duty         (duty),
  .last_of_tick (last_of_tick)
);

`default_nettype wire

>>> dv/fan_speed_policy_hysteresis_tb.sv
// Testbench for the fan speed policy block: queue driver, result monitor, predictor.
`timescale 1ns / 1ps

module fan_speed_policy_hysteresis_tb import fsph_pkg::*; ();

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 190;
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    logic [7:0] cpu;
    logic [7:0] gpu;
  } reading_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  reg_index_t cfg_addr = REG_BASE_SPEED;
  logic [7:0] cfg_data = 8'd0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] cpu_temp = 8'd0;
  logic [7:0] gpu_temp = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic       fan_index;
  logic [7:0] duty;
  logic       last_of_tick;

  fan_speed_policy_hysteresis dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .cpu_temp     (cpu_temp),
    .gpu_temp     (gpu_temp),
    .empty        (empty),
    .pop          (pop),
    .fan_index    (fan_index),
    .duty         (duty),
    .last_of_tick (last_of_tick)
  );

  always #10 clk = ~clk;

  // Policy state as the block should hold it.
  cfg_t       cfg_m = '{BASE_SPEED_RESET, CPU_THRESH_RESET, GPU_THRESH_RESET, TWO_FANS_RESET};
  int         last_excess [2] = '{int'(REM_RESET), int'(REM_RESET)};
  logic [7:0] fan_duty [2] = '{DUTY_RESET, DUTY_RESET};

  res_t     tick_cmds [$];
  res_t     fan_cmd_q [$];
  reading_t readings_q [$];

  int errors = 0;
  bit idle_on = 1'b0;
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_wait = 0;
  int tx_wait = 0;
  reading_t next_reading;

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void command_fan(bit fan, logic [7:0] d);
    res_t c;
    if (fan_duty[fan] == d) return;
    fan_duty[fan] = d;
    c.fan_index    = fan;
    c.duty         = d;
    c.last_of_tick = 1'b0;
    tick_cmds.push_back(c);
  endfunction

  function automatic void command_both(logic [7:0] d);
    command_fan(1'b0, d);
    if (cfg_m.two_fans) command_fan(1'b1, d);
  endfunction

  function automatic void predict_fan_commands(logic [7:0] ct, logic [7:0] gt);
    int temp [2];
    int lim [2];
    int excess;
    int diff;
    int base;
    int stride;
    int d;
    int slot;
    int prev;
    temp[0] = int'(ct);
    temp[1] = int'(gt);
    lim[0]  = int'(cfg_m.cpu_thresh);
    lim[1]  = int'(cfg_m.gpu_thresh);
    base    = int'(cfg_m.base_speed);
    prev    = 0;
    tick_cmds.delete();
    for (int ch = 0; ch < 2; ch++) begin
      slot   = (cfg_m.two_fans && ch == 1) ? 1 : 0;
      excess = temp[ch] - lim[ch];
      if (excess >= 0) begin
        diff = excess - last_excess[slot];
        if (diff < 2 && diff > -2) continue;
        stride = (255 - base) / 7;
        d = base + (excess - 1) * stride;
        if (d < base) d = base;
        if (d > 255) d = 255;
        command_both(d[7:0]);
        last_excess[slot] = excess;
        break;
      end else if (excess < -2 && ch == 1 && prev < -1) begin
        command_both(DUTY_STOP);
      end
      prev = excess;
    end
    if (tick_cmds.size() > 0) tick_cmds[tick_cmds.size() - 1].last_of_tick = 1'b1;
    foreach (tick_cmds[i]) fan_cmd_q.push_back(tick_cmds[i]);
  endfunction

  // Sender: one item per transfer, random gap after each item when idle_on is set.
  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      tx_wait = 0;
    end else begin
      if (push && !full) predict_fan_commands(cpu_temp, gpu_temp);
      if (!(push && full)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          push <= 1'b0;
        end else if (readings_q.size() > 0) begin
          next_reading = readings_q.pop_front();
          cpu_temp <= next_reading.cpu;
          gpu_temp <= next_reading.gpu;
          push     <= 1'b1;
          tx_wait  = idle_on ? int'($urandom_range(0, 4)) : 0;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer against the oldest expected command.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (fan_cmd_q.size() == 0) begin
          report($sformatf("unexpected command fan=%0d duty=%0d last=%0d",
                           fan_index, duty, last_of_tick));
        end else begin
          want = fan_cmd_q.pop_front();
          if (fan_index !== want.fan_index)
            report($sformatf("fan_index %0d, expected %0d", fan_index, want.fan_index));
          if (duty !== want.duty)
            report($sformatf("duty %0d, expected %0d", duty, want.duty));
          if (last_of_tick !== want.last_of_tick)
            report($sformatf("last_of_tick %0d, expected %0d",
                             last_of_tick, want.last_of_tick));
        end
        rx_wait = idle_on ? int'($urandom_range(0, 4)) : 0;
      end
      if (hold_served != hold_req) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic cfg_write(reg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_BASE_SPEED: cfg_m.base_speed = val;
      REG_CPU_THRESH: cfg_m.cpu_thresh = val;
      REG_GPU_THRESH: cfg_m.gpu_thresh = val;
      REG_TWO_FANS:   cfg_m.two_fans   = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [7:0] base, logic [7:0] cpu_lim, logic [7:0] gpu_lim,
                           logic two);
    cfg_write(REG_BASE_SPEED, base);
    cfg_write(REG_CPU_THRESH, cpu_lim);
    cfg_write(REG_GPU_THRESH, gpu_lim);
    cfg_write(REG_TWO_FANS, {7'd0, two});
  endtask

  task automatic wait_idle();
    while (readings_q.size() != 0 || push || fan_cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] near_limit(logic [7:0] lim);
    int v;
    v = int'(lim) + int'($urandom_range(0, 16)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic void add_readings(int n);
    reading_t r;
    repeat (n) begin
      if ($urandom_range(0, 99) < 85) begin
        r.cpu = near_limit(cfg_m.cpu_thresh);
        r.gpu = near_limit(cfg_m.gpu_thresh);
      end else begin
        r.cpu = 8'($urandom_range(0, 255));
        r.gpu = 8'($urandom_range(0, 255));
      end
      readings_q.push_back(r);
    end
  endfunction

  initial begin
    reading_t directed [$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    configure(BASE_SPEED_RESET, CPU_THRESH_RESET, GPU_THRESH_RESET, TWO_FANS_RESET);
    directed = '{
      '{8'd0,   8'd0},   '{8'd255, 8'd255}, '{8'd255, 8'd255}, '{8'd50,  8'd0},
      '{8'd51,  8'd0},   '{8'd0,   8'd0},   '{8'd49,  8'd0},   '{8'd60,  8'd0},
      '{8'd48,  8'd0},   '{8'd0,   8'd70},  '{8'd0,   8'd71},  '{8'd0,   8'd72},
      '{8'd0,   8'd67},  '{8'd52,  8'd67},  '{8'hAA,  8'h55},  '{8'h55,  8'hAA},
      '{8'hFF,  8'd0},   '{8'd0,   8'hFF},  '{8'd51,  8'd69},  '{8'd47,  8'd66}
    };
    foreach (directed[i]) readings_q.push_back(directed[i]);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(BASE_SPEED_RESET, CPU_THRESH_RESET, GPU_THRESH_RESET, 1'b0);
        1: configure(8'd0, 8'd0, 8'd0, 1'b1);
        2: configure(8'd255, 8'd255, 8'd255, 1'b0);
        3: configure(8'd255, 8'd40, 8'd60, 1'b1);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(20, 230)),
                           8'($urandom_range(20, 230)), 1'($urandom_range(0, 1)));
      endcase
      idle_on = ph[0];
      if (ph == 2 || ph == 5) hold_req++;
      add_readings(PHASE_ITEMS);
      wait_idle();
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/fsph_pkg.sv
rtl/fsph_front.sv
rtl/fsph_back.sv
rtl/fsph_outq.sv
rtl/fan_speed_policy_hysteresis.sv
rtl/fsph_checker.sv
dv/fan_speed_policy_hysteresis_tb.sv
